FILE: sv/relay_switch_rate_guard_unit_defines.svh
// Assertion macros shared by the relay switch rate guard checker.
// No dependencies; included by files that assert.
`ifndef RELAY_SWITCH_RATE_GUARD_UNIT_DEFINES_SVH
`define RELAY_SWITCH_RATE_GUARD_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset
`define RSRG_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset
`define RSRG_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/rsrg_pkg.sv
// Shared types, codes and defaults for the relay switch rate guard.
// No dependencies.
package rsrg_pkg;

    // Default sizing
    localparam int RELAY_COUNT_DEF = 8;
    localparam int TIME_BITS_DEF   = 32;

    // Configuration port
    localparam int PADDR_W = 5;
    localparam int PDATA_W = 32;

    // Register indexes
    localparam logic [2:0] REG_MIN_INTERVAL = 3'd0;
    localparam logic [2:0] REG_MAX_TOGGLES  = 3'd1;
    localparam logic [2:0] REG_WINDOW_LEN   = 3'd2;
    localparam logic [2:0] REG_PUMP_HOLD    = 3'd3;
    localparam logic [2:0] REG_HEAT_PUMP    = 3'd4;
    localparam logic [2:0] REG_SECOND_PUMP  = 3'd5;

    // Register reset values
    localparam logic [15:0] MIN_INTERVAL_RST = 16'd1000;
    localparam logic [7:0]  MAX_TOGGLES_RST  = 8'd10;
    localparam logic [31:0] WINDOW_LEN_RST   = 32'd60000;
    localparam logic [31:0] PUMP_HOLD_RST    = 32'd30000;
    localparam logic [3:0]  HEAT_PUMP_RST    = 4'd5;
    localparam logic [3:0]  SECOND_PUMP_RST  = 4'd6;

    // Action codes
    localparam logic [2:0] ACT_TICK       = 3'd0;
    localparam logic [2:0] ACT_SET_ONE    = 3'd1;
    localparam logic [2:0] ACT_TOGGLE_ONE = 3'd2;
    localparam logic [2:0] ACT_SET_ALL    = 3'd3;
    localparam logic [2:0] ACT_SET_MASK   = 3'd4;
    localparam logic [2:0] ACT_TOGGLE_ALL = 3'd5;
    localparam logic [2:0] ACT_READBACK   = 3'd6;

    // Status codes
    localparam logic [2:0] ST_DONE      = 3'd0;
    localparam logic [2:0] ST_ALREADY   = 3'd1;
    localparam logic [2:0] ST_BAD_NUM   = 3'd2;
    localparam logic [2:0] ST_TOO_SOON  = 3'd3;
    localparam logic [2:0] ST_QUOTA     = 3'd4;
    localparam logic [2:0] ST_PUMP_HOLD = 3'd5;

    // Live configuration, register block to core
    typedef struct packed {
        logic [15:0] min_interval;
        logic [7:0]  max_toggles;
        logic [31:0] window_len;
        logic [31:0] pump_hold;
        logic [3:0]  heat_pump;
        logic [3:0]  second_pump;
    } cfg_t;

    // One request as held in the input register
    typedef struct packed {
        logic [2:0] action;
        logic [7:0] relay_number;
        logic       new_state;
        logic [7:0] relay_mask;
    } req_t;

    // One result
    typedef struct packed {
        logic [2:0]  status;
        logic [7:0]  desired_out;
        logic [7:0]  tracked_out;
        logic [31:0] pump_wait_left;
        logic [31:0] accepted_total;
    } res_t;

endpackage

FILE: sv/rsrg_cfg.sv
// APB-style configuration registers of the relay switch rate guard.
// Depends on rsrg_pkg.
module rsrg_cfg import rsrg_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    output cfg_t               cfg
);

    cfg_t       cfg_reg;
    logic       wr_en;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = paddr[PADDR_W-1:2];
    assign cfg     = cfg_reg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.min_interval <= MIN_INTERVAL_RST;
            cfg_reg.max_toggles  <= MAX_TOGGLES_RST;
            cfg_reg.window_len   <= WINDOW_LEN_RST;
            cfg_reg.pump_hold    <= PUMP_HOLD_RST;
            cfg_reg.heat_pump    <= HEAT_PUMP_RST;
            cfg_reg.second_pump  <= SECOND_PUMP_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MIN_INTERVAL: cfg_reg.min_interval <= pwdata[15:0];
                REG_MAX_TOGGLES:  cfg_reg.max_toggles  <= pwdata[7:0];
                REG_WINDOW_LEN:   cfg_reg.window_len   <= pwdata;
                REG_PUMP_HOLD:    cfg_reg.pump_hold    <= pwdata;
                REG_HEAT_PUMP:    cfg_reg.heat_pump    <= pwdata[3:0];
                REG_SECOND_PUMP:  cfg_reg.second_pump  <= pwdata[3:0];
                default: ;
            endcase
        end
    end

    // Read-back mux
    always_comb begin
        case (reg_idx)
            REG_MIN_INTERVAL: prdata = {16'd0, cfg_reg.min_interval};
            REG_MAX_TOGGLES:  prdata = {24'd0, cfg_reg.max_toggles};
            REG_WINDOW_LEN:   prdata = cfg_reg.window_len;
            REG_PUMP_HOLD:    prdata = cfg_reg.pump_hold;
            REG_HEAT_PUMP:    prdata = {28'd0, cfg_reg.heat_pump};
            REG_SECOND_PUMP:  prdata = {28'd0, cfg_reg.second_pump};
            default:          prdata = '0;
        endcase
    end

endmodule

FILE: sv/rsrg_core.sv
// Relay guard state and the single-pass step logic for one request.
// Depends on rsrg_pkg; driven by the top level's input register.
module rsrg_core import rsrg_pkg::*; #(
    parameter int RELAY_COUNT = RELAY_COUNT_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic aclk,
    input  logic aresetn,
    input  cfg_t cfg,
    input  req_t req,
    input  logic step_en,
    output res_t res
);

    localparam int CMP_W = (TIME_BITS > 32) ? TIME_BITS : 32;

    typedef logic [TIME_BITS-1:0]   time_t;
    typedef logic [RELAY_COUNT-1:0] mask_t;

    time_t       now_reg,  now_next;
    time_t       wstart_reg, wstart_next;
    time_t       lst_reg  [RELAY_COUNT];
    time_t       lst_next [RELAY_COUNT];
    mask_t       lsv_reg,  lsv_next;
    logic [7:0]  tc_reg   [RELAY_COUNT];
    logic [7:0]  tc_next  [RELAY_COUNT];
    time_t       pct_reg  [2];
    time_t       pct_next [2];
    logic [1:0]  pcv_reg,  pcv_next;
    mask_t       des_reg,  des_next;
    mask_t       trk_reg,  trk_next;
    logic        known_reg, known_next;
    logic [31:0] acc_reg,  acc_next;

    // Request decode
    logic        rn_ok, slot0, slot1, is_set_one, tgt;
    mask_t       hit, mask_in;
    time_t       sel_lst, sel_pct, el_sw;
    logic        sel_lsv, sel_des, sel_trk, sel_pcv, pump_blk;
    logic [7:0]  sel_tc;
    logic [2:0]  status;
    logic [CMP_W-1:0] el_pump, el_left;
    time_t       left_pct;
    logic        left_pcv;
    logic [31:0] wait_left;

    assign rn_ok      = (req.relay_number >= 8'd1) &&
                        ({24'd0, req.relay_number} <= 32'(RELAY_COUNT));
    assign slot0      = (req.relay_number == {4'd0, cfg.heat_pump});
    assign slot1      = !slot0 && (req.relay_number == {4'd0, cfg.second_pump});
    assign is_set_one = (req.action == ACT_SET_ONE);
    assign mask_in    = RELAY_COUNT'(req.relay_mask);

    // One-hot relay select and per-relay state pick
    always_comb begin
        sel_lst = '0;
        sel_lsv = 1'b0;
        sel_tc  = '0;
        sel_des = 1'b0;
        sel_trk = 1'b0;
        for (int i = 0; i < RELAY_COUNT; i++) begin
            hit[i] = rn_ok && ({24'd0, req.relay_number} == 32'(i + 1));
            if (hit[i]) begin
                sel_lst = lst_reg[i];
                sel_lsv = lsv_reg[i];
                sel_tc  = tc_reg[i];
                sel_des = des_reg[i];
                sel_trk = trk_reg[i];
            end
        end
    end

    // Switch target and the checks that gate it
    assign tgt      = is_set_one ? req.new_state : !sel_des;
    assign el_sw    = now_reg - sel_lst;
    assign sel_pct  = slot0 ? pct_reg[0] : pct_reg[1];
    assign sel_pcv  = slot0 ? pcv_reg[0] : (slot1 && pcv_reg[1]);
    assign el_pump  = CMP_W'(time_t'(now_reg - sel_pct));
    assign pump_blk = sel_pcv && !(known_reg && (sel_trk == tgt)) &&
                      (el_pump < CMP_W'(cfg.pump_hold));

    // Next state
    always_comb begin
        now_next    = now_reg;
        wstart_next = wstart_reg;
        lst_next    = lst_reg;
        lsv_next    = lsv_reg;
        tc_next     = tc_reg;
        pct_next    = pct_reg;
        pcv_next    = pcv_reg;
        des_next    = des_reg;
        trk_next    = trk_reg;
        known_next  = known_reg;
        acc_next    = acc_reg;
        status      = ST_DONE;
        case (req.action)
            ACT_TICK: begin
                now_next = now_reg + time_t'(1);
                if (CMP_W'(time_t'(now_next - wstart_reg)) >= CMP_W'(cfg.window_len)) begin
                    for (int i = 0; i < RELAY_COUNT; i++) tc_next[i] = '0;
                    wstart_next = now_next;
                end
            end
            ACT_SET_ONE, ACT_TOGGLE_ONE: begin
                if (!rn_ok) begin
                    status = ST_BAD_NUM;
                end else if (is_set_one && known_reg && (sel_trk == req.new_state)) begin
                    status = ST_ALREADY;
                end else if (sel_lsv && (el_sw < TIME_BITS'(cfg.min_interval))) begin
                    status = ST_TOO_SOON;
                end else if (sel_tc >= cfg.max_toggles) begin
                    status = ST_QUOTA;
                end else begin
                    // Passed interval and quota: the switch is charged either way
                    for (int i = 0; i < RELAY_COUNT; i++) begin
                        if (hit[i]) begin
                            lst_next[i] = now_reg;
                            lsv_next[i] = 1'b1;
                            tc_next[i]  = tc_reg[i] + 8'd1;
                        end
                    end
                    if (pump_blk) begin
                        status = ST_PUMP_HOLD;
                    end else begin
                        for (int i = 0; i < RELAY_COUNT; i++) begin
                            if (hit[i]) begin
                                des_next[i] = tgt;
                                trk_next[i] = tgt;
                            end
                        end
                        if (slot0) begin
                            pct_next[0] = now_reg;
                            pcv_next[0] = 1'b1;
                        end else if (slot1) begin
                            pct_next[1] = now_reg;
                            pcv_next[1] = 1'b1;
                        end
                        known_next = 1'b1;
                        acc_next   = acc_reg + 32'd1;
                    end
                end
            end
            ACT_SET_ALL: begin
                des_next   = req.new_state ? '1 : '0;
                trk_next   = req.new_state ? '1 : '0;
                known_next = 1'b1;
            end
            ACT_SET_MASK: begin
                des_next   = mask_in;
                trk_next   = mask_in;
                known_next = 1'b1;
            end
            ACT_TOGGLE_ALL: begin
                des_next   = ~des_reg;
                trk_next   = ~des_reg;
                known_next = 1'b1;
            end
            ACT_READBACK: begin
                trk_next   = mask_in;
                known_next = 1'b1;
            end
            default: ;
        endcase
    end

    // Pump hold left, seen after the step
    assign left_pct = slot0 ? pct_next[0] : pct_next[1];
    assign left_pcv = slot0 ? pcv_next[0] : (slot1 && pcv_next[1]);
    assign el_left  = CMP_W'(time_t'(now_next - left_pct));

    always_comb begin
        if (rn_ok && left_pcv && (el_left < CMP_W'(cfg.pump_hold))) begin
            wait_left = 32'(CMP_W'(cfg.pump_hold) - el_left);
        end else begin
            wait_left = '0;
        end
    end

    assign res.status         = status;
    assign res.desired_out    = 8'(des_next);
    assign res.tracked_out    = 8'(trk_next);
    assign res.pump_wait_left = wait_left;
    assign res.accepted_total = acc_next;

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            now_reg    <= '0;
            wstart_reg <= '0;
            lsv_reg    <= '0;
            pcv_reg    <= '0;
            des_reg    <= '0;
            trk_reg    <= '0;
            known_reg  <= 1'b0;
            acc_reg    <= '0;
            for (int i = 0; i < RELAY_COUNT; i++) tc_reg[i] <= '0;
        end else if (step_en) begin
            now_reg    <= now_next;
            wstart_reg <= wstart_next;
            lsv_reg    <= lsv_next;
            pcv_reg    <= pcv_next;
            des_reg    <= des_next;
            trk_reg    <= trk_next;
            known_reg  <= known_next;
            acc_reg    <= acc_next;
            tc_reg     <= tc_next;
        end
    end

    // Timestamps, qualified by their valid bits
    always_ff @(posedge aclk) begin
        if (step_en) begin
            lst_reg <= lst_next;
            pct_reg <= pct_next;
        end
    end

endmodule

FILE: sv/relay_switch_rate_guard_unit.sv
// Relay switch rate guard: input register, single-pass step core, result register.
// Requests pass the input register, then the result register, on to result valid.
// Throughput: one request per cycle while m_ready holds; the core is combinational.
// Reset (aresetn low, synchronous): pipeline empty, guard state cleared, registers to defaults.
// Depends on rsrg_pkg, rsrg_cfg and rsrg_core.
module relay_switch_rate_guard_unit import rsrg_pkg::*; #(
    parameter int RELAY_COUNT = RELAY_COUNT_DEF,
    parameter int TIME_BITS   = TIME_BITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [PADDR_W-1:0] paddr,
    input  logic [PDATA_W-1:0] pwdata,
    output logic [PDATA_W-1:0] prdata,
    output logic               pready,
    // requests
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [2:0]         s_action,
    input  logic [7:0]         s_relay_number,
    input  logic               s_new_state,
    input  logic [7:0]         s_relay_mask,
    // results
    output logic               m_valid,
    input  logic               m_ready,
    output logic [2:0]         m_status,
    output logic [7:0]         m_desired_out,
    output logic [7:0]         m_tracked_out,
    output logic [31:0]        m_pump_wait_left,
    output logic [31:0]        m_accepted_total
);

    cfg_t cfg;
    req_t req_reg;
    res_t res, res_reg;
    logic in_valid_reg, in_valid_next;
    logic out_valid_reg, out_valid_next;
    logic advance;

    rsrg_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    rsrg_core #(
        .RELAY_COUNT (RELAY_COUNT),
        .TIME_BITS   (TIME_BITS)
    ) u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg),
        .req     (req_reg),
        .step_en (advance),
        .res     (res)
    );

    // Held request moves on when the result register is free
    assign advance        = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready        = !in_valid_reg || advance;
    assign in_valid_next  = (s_valid && s_ready) || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && !m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg.action       <= s_action;
            req_reg.relay_number <= s_relay_number;
            req_reg.new_state    <= s_new_state;
            req_reg.relay_mask   <= s_relay_mask;
        end
        if (advance) begin
            res_reg <= res;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_status         = res_reg.status;
    assign m_desired_out    = res_reg.desired_out;
    assign m_tracked_out    = res_reg.tracked_out;
    assign m_pump_wait_left = res_reg.pump_wait_left;
    assign m_accepted_total = res_reg.accepted_total;

endmodule

FILE: sv/rsrg_checker.sv
// Port-level checks on the relay switch rate guard, bound to the top level.
// Depends on rsrg_pkg and relay_switch_rate_guard_unit_defines.svh.
`include "relay_switch_rate_guard_unit_defines.svh"

module rsrg_checker import rsrg_pkg::*; (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_ready,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_status,
    input logic [7:0]  m_desired_out,
    input logic [7:0]  m_tracked_out,
    input logic [31:0] m_pump_wait_left,
    input logic [31:0] m_accepted_total
);

    logic        seen_reg;
    logic [31:0] last_total_reg;

    // Remember the success count of the last delivered result
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seen_reg <= 1'b0;
        end else if (m_valid && m_ready) begin
            seen_reg <= 1'b1;
        end
        if (m_valid && m_ready) begin
            last_total_reg <= m_accepted_total;
        end
    end

    // A stalled result holds
    `RSRG_ASSERT_NEXT(a_res_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_desired_out) && $stable(m_tracked_out) && $stable(m_pump_wait_left) && $stable(m_accepted_total), "stalled result changed")

    // Requests back up only behind a stalled result
    `RSRG_ASSERT_NOW(a_stall_cause, !s_ready, m_valid && !m_ready, "request stalled without output stall")

    // A bad relay number reports no pump hold
    `RSRG_ASSERT_NOW(a_bad_no_wait, m_valid && (m_status == ST_BAD_NUM), m_pump_wait_left == 32'd0, "pump wait on bad relay number")

    // The success count grows by at most one per result
    `RSRG_ASSERT_NOW(a_total_step, m_valid && m_ready && seen_reg, (m_accepted_total == last_total_reg) || (m_accepted_total == last_total_reg + 32'd1), "success count jumped")

endmodule

bind relay_switch_rate_guard_unit rsrg_checker u_rsrg_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_desired_out    (m_desired_out),
    .m_tracked_out    (m_tracked_out),
    .m_pump_wait_left (m_pump_wait_left),
    .m_accepted_total (m_accepted_total)
);

FILE: verif/relay_switch_rate_guard_unit_tb.sv
// Self-checking testbench for relay_switch_rate_guard_unit: directed and random requests,
// checked against an in-bench predictor of the relay guard. Depends on rsrg_pkg and the RTL.
`timescale 1ns / 100ps

module relay_switch_rate_guard_unit_tb import rsrg_pkg::*; ();

    localparam int          CYCLE_LIMIT  = 200000;
    localparam int          PRINT_CAP    = 40;
    localparam logic [2:0]  ACT_UNUSED   = 3'd7;
    localparam logic [7:0]  ALL_RELAYS   = 8'hFF;
    localparam int          NUM_RELAYS   = 8;

    typedef enum int { IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH } idle_mode_e;

    // Clock, reset and DUT pins
    logic               aclk    = 1'b0;
    logic               aresetn = 1'b0;
    logic               psel    = 1'b0;
    logic               penable = 1'b0;
    logic               pwrite  = 1'b0;
    logic [PADDR_W-1:0] paddr   = '0;
    logic [PDATA_W-1:0] pwdata  = '0;
    logic [PDATA_W-1:0] prdata;
    logic               pready;
    logic               s_valid        = 1'b0;
    logic               s_ready;
    logic [2:0]         s_action       = ACT_TICK;
    logic [7:0]         s_relay_number = '0;
    logic               s_new_state    = 1'b0;
    logic [7:0]         s_relay_mask   = '0;
    logic               m_valid;
    logic               m_ready        = 1'b0;
    logic [2:0]         m_status;
    logic [7:0]         m_desired_out;
    logic [7:0]         m_tracked_out;
    logic [31:0]        m_pump_wait_left;
    logic [31:0]        m_accepted_total;

    // Guard state mirrored by the predictor
    cfg_t        live_cfg;
    logic [31:0] clock_now;
    logic [31:0] window_origin;
    logic [31:0] last_sw_time [NUM_RELAYS];
    logic        last_sw_seen [NUM_RELAYS];
    logic [7:0]  sw_count     [NUM_RELAYS];
    logic [31:0] pump_time    [2];
    logic        pump_seen    [2];
    logic [7:0]  want_mask;
    logic [7:0]  track_mask;
    logic        track_valid;
    logic [31:0] accept_cnt;

    res_t pending_results [$];
    int   mismatch_count = 0;
    int   cycle_count    = 0;
    int   send_idle_pct  = 0;
    int   recv_stall_pct = 0;
    int   hold_len       = 0;
    int   hold_token     = 0;
    int   hold_seen      = 0;
    int   hold_left      = 0;

    relay_switch_rate_guard_unit dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .psel             (psel),
        .penable          (penable),
        .pwrite           (pwrite),
        .paddr            (paddr),
        .pwdata           (pwdata),
        .prdata           (prdata),
        .pready           (pready),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_relay_number   (s_relay_number),
        .s_new_state      (s_new_state),
        .s_relay_mask     (s_relay_mask),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_desired_out    (m_desired_out),
        .m_tracked_out    (m_tracked_out),
        .m_pump_wait_left (m_pump_wait_left),
        .m_accepted_total (m_accepted_total)
    );

    // 8 ns clock
    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Run-away guard
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result-side ready: random stalls, or a long hold-off when one is requested
    always @(posedge aclk) begin
        if (hold_token != hold_seen) begin
            hold_seen <= hold_token;
            hold_left <= hold_len;
            m_ready   <= 1'b0;
        end else if (hold_left != 0) begin
            hold_left <= hold_left - 1;
            m_ready   <= 1'b0;
        end else begin
            m_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
        end
    end

    // ---------------------------------------------------------------- predictor

    function automatic void clear_guard_state();
        live_cfg.min_interval = MIN_INTERVAL_RST;
        live_cfg.max_toggles  = MAX_TOGGLES_RST;
        live_cfg.window_len   = WINDOW_LEN_RST;
        live_cfg.pump_hold    = PUMP_HOLD_RST;
        live_cfg.heat_pump    = HEAT_PUMP_RST;
        live_cfg.second_pump  = SECOND_PUMP_RST;
        clock_now     = '0;
        window_origin = '0;
        for (int i = 0; i < NUM_RELAYS; i++) begin
            last_sw_time[i] = '0;
            last_sw_seen[i] = 1'b0;
            sw_count[i]     = '0;
        end
        for (int i = 0; i < 2; i++) begin
            pump_time[i] = '0;
            pump_seen[i] = 1'b0;
        end
        want_mask   = '0;
        track_mask  = '0;
        track_valid = 1'b0;
        accept_cnt  = '0;
    endfunction

    // Heating pump slot wins when both registers name the same relay
    function automatic int pump_slot_of(input logic [7:0] rn);
        if (rn == {4'd0, live_cfg.heat_pump}) return 0;
        if (rn == {4'd0, live_cfg.second_pump}) return 1;
        return -1;
    endfunction

    function automatic logic [31:0] hold_remaining(input logic [7:0] rn);
        int          slot;
        logic [31:0] elapsed;
        if (rn < 8'd1 || rn > 8'(NUM_RELAYS)) return '0;
        slot = pump_slot_of(rn);
        if (slot < 0 || !pump_seen[slot]) return '0;
        elapsed = clock_now - pump_time[slot];
        if (elapsed >= live_cfg.pump_hold) return '0;
        return live_cfg.pump_hold - elapsed;
    endfunction

    // Interval, quota, then pump hold; the quota is spent even when the hold blocks
    function automatic logic [2:0] guard_switch(input int idx, input logic target);
        int          slot;
        logic        same;
        logic [31:0] elapsed;
        elapsed = clock_now - last_sw_time[idx];
        if (last_sw_seen[idx] && elapsed < {16'd0, live_cfg.min_interval}) return ST_TOO_SOON;
        if (sw_count[idx] >= live_cfg.max_toggles) return ST_QUOTA;
        last_sw_time[idx] = clock_now;
        last_sw_seen[idx] = 1'b1;
        sw_count[idx]     = sw_count[idx] + 8'd1;

        slot = pump_slot_of(8'(idx + 1));
        if (slot >= 0 && pump_seen[slot]) begin
            same    = track_valid && (track_mask[idx] == target);
            elapsed = clock_now - pump_time[slot];
            if (!same && elapsed < live_cfg.pump_hold) return ST_PUMP_HOLD;
        end

        want_mask[idx] = target;
        if (slot >= 0) begin
            pump_time[slot] = clock_now;
            pump_seen[slot] = 1'b1;
        end
        track_mask[idx] = target;
        track_valid     = 1'b1;
        accept_cnt      = accept_cnt + 32'd1;
        return ST_DONE;
    endfunction

    function automatic res_t predict_step(input req_t r);
        res_t        exp_res;
        logic [2:0]  code;
        logic        num_ok;
        int          idx;
        code   = ST_DONE;
        num_ok = (r.relay_number >= 8'd1) && (r.relay_number <= 8'(NUM_RELAYS));
        idx    = int'(r.relay_number) - 1;
        case (r.action)
            ACT_TICK: begin
                clock_now = clock_now + 32'd1;
                if (clock_now - window_origin >= live_cfg.window_len) begin
                    for (int i = 0; i < NUM_RELAYS; i++) sw_count[i] = '0;
                    window_origin = clock_now;
                end
            end
            ACT_SET_ONE: begin
                if (!num_ok)
                    code = ST_BAD_NUM;
                else if (track_valid && track_mask[idx] == r.new_state)
                    code = ST_ALREADY;
                else
                    code = guard_switch(idx, r.new_state);
            end
            ACT_TOGGLE_ONE: begin
                if (!num_ok)
                    code = ST_BAD_NUM;
                else
                    code = guard_switch(idx, !want_mask[idx]);
            end
            ACT_SET_ALL: begin
                want_mask   = r.new_state ? ALL_RELAYS : 8'h00;
                track_mask  = want_mask;
                track_valid = 1'b1;
            end
            ACT_SET_MASK: begin
                want_mask   = r.relay_mask & ALL_RELAYS;
                track_mask  = want_mask;
                track_valid = 1'b1;
            end
            ACT_TOGGLE_ALL: begin
                want_mask   = ~want_mask & ALL_RELAYS;
                track_mask  = want_mask;
                track_valid = 1'b1;
            end
            ACT_READBACK: begin
                track_mask  = r.relay_mask & ALL_RELAYS;
                track_valid = 1'b1;
            end
            default: ;
        endcase
        exp_res.status         = code;
        exp_res.desired_out    = want_mask;
        exp_res.tracked_out    = track_mask;
        exp_res.pump_wait_left = hold_remaining(r.relay_number);
        exp_res.accepted_total = accept_cnt;
        return exp_res;
    endfunction

    // ---------------------------------------------------------------- checking

    task automatic report_mismatch(input string what, input logic [31:0] want,
                                   input logic [31:0] got);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch %s: expected 0x%0h got 0x%0h (cycle %0d)",
                     what, want, got, cycle_count);
        mismatch_count++;
    endtask

    task automatic check_field(input string what, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want) report_mismatch(what, want, got);
    endtask

    // Compare each accepted result with the oldest outstanding prediction
    always @(posedge aclk) begin : result_monitor
        res_t want;
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("result with no request pending", '0, {29'd0, m_status});
            end else begin
                want = pending_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_status));
                check_field("desired_out", 32'(want.desired_out), 32'(m_desired_out));
                check_field("tracked_out", 32'(want.tracked_out), 32'(m_tracked_out));
                check_field("pump_wait_left", want.pump_wait_left, m_pump_wait_left);
                check_field("accepted_total", want.accepted_total, m_accepted_total);
            end
        end
    end

    // ---------------------------------------------------------------- drivers

    // APB write: setup phase, access phase held until pready, then back to idle
    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_INTERVAL: live_cfg.min_interval = val[15:0];
            REG_MAX_TOGGLES:  live_cfg.max_toggles  = val[7:0];
            REG_WINDOW_LEN:   live_cfg.window_len   = val;
            REG_PUMP_HOLD:    live_cfg.pump_hold    = val;
            REG_HEAT_PUMP:    live_cfg.heat_pump    = val[3:0];
            REG_SECOND_PUMP:  live_cfg.second_pump  = val[3:0];
            default: ;
        endcase
        @(posedge aclk);
    endtask

    task automatic set_limits(input cfg_t c);
        write_reg(REG_MIN_INTERVAL, {16'd0, c.min_interval});
        write_reg(REG_MAX_TOGGLES, {24'd0, c.max_toggles});
        write_reg(REG_WINDOW_LEN, c.window_len);
        write_reg(REG_PUMP_HOLD, c.pump_hold);
        write_reg(REG_HEAT_PUMP, {28'd0, c.heat_pump});
        write_reg(REG_SECOND_PUMP, {28'd0, c.second_pump});
    endtask

    function automatic cfg_t make_limits(input logic [15:0] min_iv, input logic [7:0] quota,
                                         input logic [31:0] win, input logic [31:0] hold,
                                         input logic [3:0] heat, input logic [3:0] second);
        cfg_t c;
        c.min_interval = min_iv;
        c.max_toggles  = quota;
        c.window_len   = win;
        c.pump_hold    = hold;
        c.heat_pump    = heat;
        c.second_pump  = second;
        return c;
    endfunction

    function automatic req_t make_request(input logic [2:0] act, input logic [7:0] rn,
                                          input logic st, input logic [7:0] mask);
        req_t r;
        r.action       = act;
        r.relay_number = rn;
        r.new_state    = st;
        r.relay_mask   = mask;
        return r;
    endfunction

    // Mostly valid relay numbers and switch commands; a few bad numbers and unused actions
    function automatic req_t random_request();
        req_t r;
        int   pick;
        r.relay_number = ($urandom_range(0, 9) == 0) ? 8'($urandom_range(0, 255))
                                                     : 8'($urandom_range(1, NUM_RELAYS));
        r.new_state    = 1'($urandom_range(0, 1));
        r.relay_mask   = 8'($urandom_range(0, 255));
        pick = $urandom_range(0, 99);
        if (pick < 38)      r.action = ACT_TICK;
        else if (pick < 60) r.action = ACT_SET_ONE;
        else if (pick < 80) r.action = ACT_TOGGLE_ONE;
        else if (pick < 85) r.action = ACT_SET_ALL;
        else if (pick < 89) r.action = ACT_SET_MASK;
        else if (pick < 93) r.action = ACT_TOGGLE_ALL;
        else if (pick < 98) r.action = ACT_READBACK;
        else                r.action = ACT_UNUSED;
        return r;
    endfunction

    // Offer one request, hold it until accepted, then queue its prediction
    task automatic send_request(input req_t r);
        while (send_idle_pct != 0 && $urandom_range(0, 99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid        <= 1'b1;
        s_action       <= r.action;
        s_relay_number <= r.relay_number;
        s_new_state    <= r.new_state;
        s_relay_mask   <= r.relay_mask;
        do @(posedge aclk); while (!s_ready);
        pending_results.push_back(predict_step(r));
    endtask

    // Stop offering and wait until every predicted result has been seen
    task automatic drain_results();
        s_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_idling(input idle_mode_e mode);
        case (mode)
            IDLE_SEND: begin send_idle_pct = 68; recv_stall_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_stall_pct = 68; end
            IDLE_BOTH: begin send_idle_pct = 16; recv_stall_pct = 16; end
            default:   begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        endcase
    endtask

    // ---------------------------------------------------------------- tests

    // Reset limits: bad numbers, already-in-state, too soon, pump timer, bulk commands
    task automatic test_reset_defaults();
        set_idling(IDLE_NONE);
        send_request(make_request(ACT_TICK, 8'd0, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd0, 1'b1, 8'hFF));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd9, 1'b1, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd255, 1'b1, 8'hFF));
        send_request(make_request(ACT_SET_ONE, 8'd3, 1'b1, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd3, 1'b1, 8'h00));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd3, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd5, 1'b1, 8'h00));
        send_request(make_request(ACT_TICK, 8'd5, 1'b0, 8'h00));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd8, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ALL, 8'd1, 1'b1, 8'h00));
        send_request(make_request(ACT_SET_ALL, 8'd1, 1'b0, 8'hFF));
        send_request(make_request(ACT_SET_MASK, 8'd5, 1'b0, 8'hA5));
        send_request(make_request(ACT_TOGGLE_ALL, 8'd6, 1'b0, 8'h00));
        send_request(make_request(ACT_READBACK, 8'd5, 1'b1, 8'h5A));
        send_request(make_request(ACT_UNUSED, 8'd5, 1'b1, 8'hFF));
    endtask

    // Tight limits: quota spent under a pump hold, quota used, window clear
    task automatic test_guard_limits();
        drain_results();
        set_limits(make_limits(16'd0, 8'd2, 32'd4, 32'd3, 4'd2, 4'd7));
        send_request(make_request(ACT_READBACK, 8'd1, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd2, 1'b1, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd2, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd2, 1'b0, 8'h00));
        repeat (4) send_request(make_request(ACT_TICK, 8'd2, 1'b0, 8'h00));
        send_request(make_request(ACT_SET_ONE, 8'd2, 1'b0, 8'h00));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd7, 1'b0, 8'h00));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd7, 1'b0, 8'h00));
        // tracked now disagrees with desired, so the toggle target already holds
        send_request(make_request(ACT_READBACK, 8'd7, 1'b0, 8'h00));
        send_request(make_request(ACT_TOGGLE_ONE, 8'd7, 1'b0, 8'h00));
    endtask

    task automatic run_random(input cfg_t c, input idle_mode_e mode, input int count);
        drain_results();
        set_limits(c);
        set_idling(mode);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(0, 99) == 0) drain_results();
            send_request(random_request());
        end
    endtask

    // Random traffic across limit settings and idling patterns, extremes included
    task automatic test_random_traffic();
        cfg_t c;
        run_random(make_limits(16'd2, 8'd3, 32'd12, 32'd6, 4'd5, 4'd6), IDLE_NONE, 150);
        run_random(make_limits(16'd1, 8'd255, 32'd3, 32'd1, 4'd1, 4'd8), IDLE_SEND, 150);
        run_random(make_limits(16'hFFFF, 8'd255, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 4'd8, 4'd8),
                   IDLE_RECV, 150);
        run_random(make_limits(16'd0, 8'd0, 32'd0, 32'd0, 4'd0, 4'd15), IDLE_BOTH, 150);
        run_random(make_limits(16'd0, 8'd1, 32'd0, 32'd2, 4'd15, 4'd3), IDLE_RECV, 60);
        for (int p = 0; p < 4; p++) begin
            c = make_limits(16'($urandom_range(0, 6)), 8'($urandom_range(0, 5)),
                            32'($urandom_range(0, 30)), 32'($urandom_range(0, 12)),
                            4'($urandom_range(1, 8)), 4'($urandom_range(1, 8)));
            run_random(c, idle_mode_e'(p), 90);
        end
    endtask

    // Long result-side hold-off fills the pipeline; then the sender waits for all results
    task automatic test_output_backpressure();
        drain_results();
        set_limits(make_limits(16'd2, 8'd4, 32'd10, 32'd5, 4'd3, 4'd4));
        set_idling(IDLE_NONE);
        hold_len   <= 60;
        hold_token <= hold_token + 1;
        for (int i = 0; i < 30; i++) send_request(random_request());
        drain_results();
        set_idling(IDLE_BOTH);
        for (int i = 0; i < 20; i++) send_request(random_request());
    endtask

    initial begin
        clear_guard_state();
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;

        test_reset_defaults();
        test_guard_limits();
        test_random_traffic();
        test_output_backpressure();

        drain_results();
        repeat (8) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
